// ===== hdl/rra_pkg.sv =====
// Shared types and constants for the RGB rotation address generator.
// No dependencies; every other file of the block imports this package.
package rra_pkg;

   localparam int DIM_W        = 13;
   localparam int PITCH_W      = 16;
   localparam int SIZE_W       = 25;
   localparam int ADDR_W       = 24;
   localparam int COORD_W      = 12;
   localparam int BYTE_W       = 8;
   localparam int ROT_W        = 2;
   localparam int PROD_W       = DIM_W + PITCH_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 25;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCOUNT_W     = 2;
   localparam int SETTLE_W     = 2;

   localparam logic [SIZE_W-1:0]   SIZE_LIMIT    = 25'h100_0000;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_ROTATION     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_PITCH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_PITCH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_SIZE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_SIZE    = 3'd6;

   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   typedef struct packed {
      logic [ROT_W-1:0]   rotation;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [PITCH_W-1:0] dest_pitch;
   } cfg_type;

   typedef struct packed {
      logic ok;
      logic busy;
   } setup_status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [DIM_W-1:0]  column;
      logic [DIM_W-1:0]  row;
      logic              last;
      logic              error;
   } entry_type;

endpackage

// ===== hdl/rra_setup.sv =====
// Configuration registers and the registered two-stage setup validity check.
// Depends on rra_pkg.
module rra_setup import rra_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg,
   output setup_status_type       status
);

   logic [ROT_W-1:0]    rotation_ff;
   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic [PITCH_W-1:0]  src_pitch_ff;
   logic [PITCH_W-1:0]  dst_pitch_ff;
   logic [SIZE_W-1:0]   src_size_ff;
   logic [SIZE_W-1:0]   dst_size_ff;
   logic [SETTLE_W-1:0] settle_ff;
   logic [SETTLE_W-1:0] settle_in;

   logic                swap;
   logic [DIM_W-1:0]    out_width;
   logic [DIM_W-1:0]    out_height;
   logic                dims_ok;
   logic [DIM_W+1:0]    src_row_bytes;
   logic [DIM_W+1:0]    dst_row_bytes;
   logic [SIZE_W-1:0]   src_limit;
   logic [SIZE_W-1:0]   dst_limit;

   logic                src_pre_ok_ff;
   logic                src_pre_ok_in;
   logic                dst_pre_ok_ff;
   logic                dst_pre_ok_in;
   logic [PROD_W-1:0]   src_prod_ff;
   logic [PROD_W-1:0]   src_prod_in;
   logic [PROD_W-1:0]   dst_prod_ff;
   logic [PROD_W-1:0]   dst_prod_in;
   logic [SIZE_W-1:0]   src_limit_ff;
   logic [SIZE_W-1:0]   dst_limit_ff;
   logic                ok_ff;
   logic                ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff  <= ROT_NONE;
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         src_pitch_ff <= PITCH_W'(3);
         dst_pitch_ff <= PITCH_W'(3);
         src_size_ff  <= SIZE_W'(3);
         dst_size_ff  <= SIZE_W'(3);
      end else if (csr_write) begin
         case (csr_index)
            REG_ROTATION:     rotation_ff  <= csr_data[ROT_W-1:0];
            REG_IMAGE_WIDTH:  width_ff     <= csr_data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff    <= csr_data[DIM_W-1:0];
            REG_SOURCE_PITCH: src_pitch_ff <= csr_data[PITCH_W-1:0];
            REG_DEST_PITCH:   dst_pitch_ff <= csr_data[PITCH_W-1:0];
            REG_SOURCE_SIZE:  src_size_ff  <= csr_data[SIZE_W-1:0];
            REG_DEST_SIZE:    dst_size_ff  <= csr_data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The check result is two registers behind the configuration, so the
   // input side is held off for that long after reset and after any write.
   always_comb begin
      if (csr_write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_comb begin
      swap          = (rotation_ff == ROT_90) || (rotation_ff == ROT_270);
      out_width     = swap ? height_ff : width_ff;
      out_height    = swap ? width_ff : height_ff;
      dims_ok       = (width_ff != '0) && (height_ff != '0) &&
                      (32'(width_ff) <= MAX_DIM) && (32'(height_ff) <= MAX_DIM);
      src_row_bytes = {2'b00, width_ff} + {1'b0, width_ff, 1'b0};
      dst_row_bytes = {2'b00, out_width} + {1'b0, out_width, 1'b0};
      src_limit     = (src_size_ff > SIZE_LIMIT) ? SIZE_LIMIT : src_size_ff;
      dst_limit     = (dst_size_ff > SIZE_LIMIT) ? SIZE_LIMIT : dst_size_ff;
      src_pre_ok_in = dims_ok && (src_pitch_ff >= {1'b0, src_row_bytes});
      dst_pre_ok_in = dims_ok && (dst_pitch_ff >= {1'b0, dst_row_bytes});
      src_prod_in   = height_ff * src_pitch_ff;
      dst_prod_in   = out_height * dst_pitch_ff;
      ok_in         = src_pre_ok_ff && dst_pre_ok_ff &&
                      (src_prod_ff <= PROD_W'(src_limit_ff)) &&
                      (dst_prod_ff <= PROD_W'(dst_limit_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff     <= SETTLE_CYCLES;
         src_pre_ok_ff <= 1'b0;
         dst_pre_ok_ff <= 1'b0;
         ok_ff         <= 1'b0;
      end else begin
         settle_ff     <= settle_in;
         src_pre_ok_ff <= src_pre_ok_in;
         dst_pre_ok_ff <= dst_pre_ok_in;
         ok_ff         <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      src_prod_ff  <= src_prod_in;
      dst_prod_ff  <= dst_prod_in;
      src_limit_ff <= src_limit;
      dst_limit_ff <= dst_limit;
   end

   assign cfg.rotation   = rotation_ff;
   assign cfg.width      = width_ff;
   assign cfg.height     = height_ff;
   assign cfg.dest_pitch = dst_pitch_ff;
   assign status.ok      = ok_ff;
   assign status.busy    = csr_write || (settle_ff != '0);

endmodule

// ===== hdl/rra_front.sv =====
// Input side: accepts pixels, keeps the source column and row counters and
// classifies each beat as placed or setup error. Depends on rra_pkg.
module rra_front import rra_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  setup_status_type     status,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_red,
   input  logic [BYTE_W-1:0]    req_green,
   input  logic [BYTE_W-1:0]    req_blue,
   input  logic                 queue_full,
   output logic                 push,
   output entry_type            push_entry
);

   localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

   logic [CNT_W-1:0] column_ff;
   logic [CNT_W-1:0] column_in;
   logic [CNT_W-1:0] row_ff;
   logic [CNT_W-1:0] row_in;
   logic             restart;
   logic [CNT_W-1:0] x;
   logic [CNT_W-1:0] y;
   logic             row_done;
   logic             frame_done;

   assign req_stall = queue_full || status.busy;
   assign push      = req_valid && !req_stall;

   always_comb begin
      restart    = (32'(column_ff) >= 32'(cfg.width)) || (32'(row_ff) >= 32'(cfg.height));
      x          = restart ? '0 : column_ff;
      y          = restart ? '0 : row_ff;
      row_done   = (32'(x) + 32'd1) >= 32'(cfg.width);
      frame_done = (32'(y) + 32'd1) >= 32'(cfg.height);
      column_in  = column_ff;
      row_in     = row_ff;
      if (push && status.ok) begin
         if (row_done) begin
            column_in = '0;
            row_in    = frame_done ? '0 : y + CNT_W'(1);
         end else begin
            column_in = x + CNT_W'(1);
            row_in    = y;
         end
      end
      push_entry.red    = req_red;
      push_entry.green  = req_green;
      push_entry.blue   = req_blue;
      push_entry.column = DIM_W'(x);
      push_entry.row    = DIM_W'(y);
      push_entry.last   = row_done && frame_done;
      push_entry.error  = !status.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== hdl/rra_queue.sv =====
// Two-entry queue between the input side and the address side.
// Depends on rra_pkg.
module rra_queue import rra_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCOUNT_W-1:0]  count_ff;
   logic [QCOUNT_W-1:0]  count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (32'(count_ff) == QUEUE_DEPTH);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/rra_back.sv =====
// Address side: maps source coordinates to rotated destination coordinates,
// forms the byte address and holds the result beat. Depends on rra_pkg.
module rra_back import rra_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  entry_type           head,
   input  logic                queue_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ADDR_W-1:0]   rsp_dest_address,
   output logic [COORD_W-1:0]  rsp_dest_column,
   output logic [COORD_W-1:0]  rsp_dest_row,
   output logic [BYTE_W-1:0]   rsp_out_red,
   output logic [BYTE_W-1:0]   rsp_out_green,
   output logic [BYTE_W-1:0]   rsp_out_blue,
   output logic                rsp_frame_end,
   output logic                rsp_setup_error
);

   logic                 load;
   logic                 valid_ff;
   logic                 valid_in;
   logic [DIM_W-1:0]     dx;
   logic [DIM_W-1:0]     dy;
   logic [PROD_W-1:0]    row_offset;
   logic [DIM_W+1:0]     column_offset;
   logic [ADDR_W-1:0]    address;
   logic [ADDR_W-1:0]    address_ff;
   logic [COORD_W-1:0]   column_ff;
   logic [COORD_W-1:0]   row_ff;
   logic [BYTE_W-1:0]    red_ff;
   logic [BYTE_W-1:0]    green_ff;
   logic [BYTE_W-1:0]    blue_ff;
   logic                 frame_end_ff;
   logic                 error_ff;

   assign load     = !valid_ff || !rsp_stall;
   assign pop      = load && !queue_empty;
   assign valid_in = load ? !queue_empty : valid_ff;

   always_comb begin
      case (cfg.rotation)
         ROT_90: begin
            dx = cfg.height - DIM_W'(1) - head.row;
            dy = head.column;
         end
         ROT_180: begin
            dx = cfg.width - DIM_W'(1) - head.column;
            dy = cfg.height - DIM_W'(1) - head.row;
         end
         ROT_270: begin
            dx = head.row;
            dy = cfg.width - DIM_W'(1) - head.column;
         end
         default: begin
            dx = head.column;
            dy = head.row;
         end
      endcase
      row_offset    = dy * cfg.dest_pitch;
      column_offset = {2'b00, dx} + {1'b0, dx, 1'b0};
      address       = ADDR_W'(row_offset) + ADDR_W'(column_offset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff       <= head.red;
         green_ff     <= head.green;
         blue_ff      <= head.blue;
         error_ff     <= head.error;
         address_ff   <= head.error ? '0 : address;
         column_ff    <= head.error ? '0 : COORD_W'(dx);
         row_ff       <= head.error ? '0 : COORD_W'(dy);
         frame_end_ff <= head.error ? 1'b0 : head.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_dest_address = address_ff;
   assign rsp_dest_column  = column_ff;
   assign rsp_dest_row     = row_ff;
   assign rsp_out_red      = red_ff;
   assign rsp_out_green    = green_ff;
   assign rsp_out_blue     = blue_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_setup_error  = error_ff;

endmodule

// ===== hdl/rgb_rotation_address_generator.sv =====
// RGB24 rotation address generator, top level.
// Instantiates rra_setup, rra_front, rra_queue and rra_back; uses rra_pkg.
//
// Usage: pixels enter in source raster order on the req_ channel (valid and
// stall, one pixel per beat). Each pixel leaves on the rsp_ channel with its
// destination column, row and byte address for a clockwise rotation of 0, 90,
// 180 or 270 degrees, its bytes unchanged, a frame-end flag on the last
// pixel and a setup-error flag when the sizes or pitches are inconsistent.
// The csr_ port writes one register per cycle. The user must write only while
// the block is idle; the block itself does not enforce it. An accepted beat
// passes through a two-entry queue into the response register, and the block
// sustains one pixel per clock while rsp_stall and req_stall stay low: the
// input side feeds the queue and the one-multiplier address side drains it.
// After reset, and after any register write, req_stall is high while the
// registered setup check settles.
// Reset clears both counters, empties the queue and drops rsp_valid. When
// the receiver stalls, the response beat holds and the queue fills; once it
// is full, req_stall rises.
module rgb_rotation_address_generator import rra_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_red,
   input  logic [BYTE_W-1:0]      req_green,
   input  logic [BYTE_W-1:0]      req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_dest_address,
   output logic [COORD_W-1:0]     rsp_dest_column,
   output logic [COORD_W-1:0]     rsp_dest_row,
   output logic [BYTE_W-1:0]      rsp_out_red,
   output logic [BYTE_W-1:0]      rsp_out_green,
   output logic [BYTE_W-1:0]      rsp_out_blue,
   output logic                   rsp_frame_end,
   output logic                   rsp_setup_error
);

   cfg_type          cfg;
   setup_status_type status;
   logic             push;
   entry_type        push_entry;
   logic             queue_full;
   logic             queue_empty;
   logic             pop;
   entry_type        head;

   rra_setup #(
      .MAX_DIM (MAX_DIM)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .status    (status)
   );

   rra_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (head),
      .empty      (queue_empty)
   );

   rra_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head             (head),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest_address (rsp_dest_address),
      .rsp_dest_column  (rsp_dest_column),
      .rsp_dest_row     (rsp_dest_row),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_setup_error  (rsp_setup_error)
   );

endmodule
